// ----- rtl/core/nmea_sentence_field_checksum_defines.svh -----
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Shared assertion forms for the sentence checksum block checkers.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FIELD_CHECKSUM_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_CHECKSUM_DEFINES_SVH

// same-cycle implication, quiet during reset
`define NSFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define NSFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/nsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checksum package
// Shared constants, register codes and word types of the sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfc_pkg;

   localparam int MAX_FIELD_LEN = 32;
   // field length counter is 6 bits wide
   localparam logic [5:0] LEN_CAP = 6'(MAX_FIELD_LEN > 63 ? 63 : MAX_FIELD_LEN);

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_FIELD_DELIM = 2'd0;
   localparam logic [1:0] REG_END_MARK    = 2'd1;
   localparam logic [1:0] REG_START_MARK  = 2'd2;

   localparam logic [7:0] RST_FIELD_DELIM = 8'd44;
   localparam logic [7:0] RST_END_MARK    = 8'd42;
   localparam logic [7:0] RST_START_MARK  = 8'd36;

   typedef struct packed {
      logic [7:0] field_delim;
      logic [7:0] end_mark;
      logic [7:0] start_mark;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [7:0] field_char;
      logic       char_valid;
      logic [7:0] field_index;
      logic       field_end;
      logic [5:0] field_length;
      logic       length_overflow;
      logic       end_marker_seen;
      logic       sentence_done;
      logic       checksum_match;
      logic [7:0] computed_checksum;
      logic [7:0] received_checksum;
   } result_type;

   // ASCII hex digit decode, both letter cases
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type    h;
      logic [7:0] diff;
      h.valid = 1'b1;
      diff    = 8'd0;
      priority if (c >= 8'h30 && c <= 8'h39) begin
         diff = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         diff = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         diff = c - 8'h37;
      end else begin
         h.valid = 1'b0;
      end
      h.value = diff[3:0];
      return h;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nmea_sentence_field_checksum.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence field splitter and checksum verifier
// Takes one sentence byte per word and returns one result word per byte.
// ----------------------------------------------------------------------------
// Each request word carries one sentence character; each yields exactly one
// response word with field index, length, field end and, on the final byte,
// the checksum verdict. Throughput is one word per clock when rsp_stall is
// low; each word passes the input register and then the result register,
// with the whole per-byte update done in a single pass between them. The field
// delimiter and the two marker bytes sit in the control registers at byte
// addresses 0, 4 and 8; write them only while no words are in flight.
`default_nettype none

module nmea_sentence_field_checksum (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_final_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [7:0]                       rsp_field_char,
   output logic                                  rsp_char_valid,
   output logic      [7:0]                       rsp_field_index,
   output logic                                  rsp_field_end,
   output logic      [5:0]                       rsp_field_length,
   output logic                                  rsp_length_overflow,
   output logic                                  rsp_end_marker_seen,
   output logic                                  rsp_sentence_done,
   output logic                                  rsp_checksum_match,
   output logic      [7:0]                       rsp_computed_checksum,
   output logic      [7:0]                       rsp_received_checksum,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [nsfc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic      [31:0]                      csr_prdata,
   output logic                                  csr_pready
);

   nsfc_pkg::cfg_type    cfg;
   nsfc_pkg::result_type result;
   nsfc_pkg::result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       advance;

   nsfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // move the held word on when the result slot is free or draining
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   nsfc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_field_char        = rsp_ff.field_char;
   assign rsp_char_valid        = rsp_ff.char_valid;
   assign rsp_field_index       = rsp_ff.field_index;
   assign rsp_field_end         = rsp_ff.field_end;
   assign rsp_field_length      = rsp_ff.field_length;
   assign rsp_length_overflow   = rsp_ff.length_overflow;
   assign rsp_end_marker_seen   = rsp_ff.end_marker_seen;
   assign rsp_sentence_done     = rsp_ff.sentence_done;
   assign rsp_checksum_match    = rsp_ff.checksum_match;
   assign rsp_computed_checksum = rsp_ff.computed_checksum;
   assign rsp_received_checksum = rsp_ff.received_checksum;

endmodule

`default_nettype wire

// ----- rtl/core/nsfc_csr.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker control registers
// APB-style register file holding the delimiter and marker bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module nsfc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [nsfc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic      [31:0]                      csr_prdata,
   output logic                                  csr_pready,
   output nsfc_pkg::cfg_type                     cfg
);

   logic [7:0] delim_ff, delim_in;
   logic [7:0] end_mark_ff, end_mark_in;
   logic [7:0] start_mark_ff, start_mark_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      delim_in      = delim_ff;
      end_mark_in   = end_mark_ff;
      start_mark_in = start_mark_ff;
      if (wr_en) begin
         unique case (reg_sel)
            nsfc_pkg::REG_FIELD_DELIM: delim_in      = csr_pwdata[7:0];
            nsfc_pkg::REG_END_MARK:    end_mark_in   = csr_pwdata[7:0];
            nsfc_pkg::REG_START_MARK:  start_mark_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff      <= nsfc_pkg::RST_FIELD_DELIM;
         end_mark_ff   <= nsfc_pkg::RST_END_MARK;
         start_mark_ff <= nsfc_pkg::RST_START_MARK;
      end else begin
         delim_ff      <= delim_in;
         end_mark_ff   <= end_mark_in;
         start_mark_ff <= start_mark_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         nsfc_pkg::REG_FIELD_DELIM: csr_prdata = {24'd0, delim_ff};
         nsfc_pkg::REG_END_MARK:    csr_prdata = {24'd0, end_mark_ff};
         nsfc_pkg::REG_START_MARK:  csr_prdata = {24'd0, start_mark_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign cfg.field_delim = delim_ff;
   assign cfg.end_mark    = end_mark_ff;
   assign cfg.start_mark  = start_mark_ff;

endmodule

`default_nettype wire

// ----- rtl/core/nsfc_core.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker byte logic
// Sentence state and the single-pass update for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module nsfc_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  final_byte,
   input  wire nsfc_pkg::cfg_type     cfg,
   output nsfc_pkg::result_type       result
);

   logic [7:0] xor_ff, xor_in;
   logic [7:0] latched_ff, latched_in;
   logic       mark_seen_ff, mark_seen_in;
   logic [7:0] field_cnt_ff, field_cnt_in;
   logic [5:0] char_cnt_ff, char_cnt_in;
   logic       ovf_ff, ovf_in;
   logic [7:0] hex_ff, hex_in;
   logic       hex_seen_ff, hex_seen_in;
   logic       hex_stop_ff, hex_stop_in;

   logic              is_delim;
   logic              is_end;
   logic              is_start;
   nsfc_pkg::hex_type digit;

   assign is_delim = (data_byte == cfg.field_delim);
   assign is_end   = (data_byte == cfg.end_mark);
   assign is_start = (data_byte == cfg.start_mark);
   assign digit    = nsfc_pkg::hex_decode(data_byte);

   always_comb begin
      xor_in       = (!is_start && !is_end) ? (xor_ff ^ data_byte) : xor_ff;
      latched_in   = latched_ff;
      mark_seen_in = mark_seen_ff;
      field_cnt_in = field_cnt_ff;
      char_cnt_in  = char_cnt_ff;
      ovf_in       = ovf_ff;
      hex_in       = hex_ff;
      hex_seen_in  = hex_seen_ff;
      hex_stop_in  = hex_stop_ff;

      result                   = '0;
      result.field_char        = data_byte;
      result.field_index       = field_cnt_ff;
      result.sentence_done     = final_byte;

      if (is_delim || is_end) begin
         result.field_end       = 1'b1;
         result.field_length    = char_cnt_ff;
         result.length_overflow = ovf_ff;
         if (!is_delim) begin
            latched_in   = xor_in;
            mark_seen_in = 1'b1;
         end
         // close the field
         field_cnt_in = (field_cnt_ff != 8'hFF) ? field_cnt_ff + 8'd1 : field_cnt_ff;
         char_cnt_in  = 6'd0;
         ovf_in       = 1'b0;
         hex_in       = 8'd0;
         hex_seen_in  = 1'b0;
         hex_stop_in  = 1'b0;
      end else begin
         result.char_valid = 1'b1;
         if (char_cnt_ff >= nsfc_pkg::LEN_CAP) begin
            ovf_in = 1'b1;
         end else begin
            char_cnt_in = char_cnt_ff + 6'd1;
         end
         if (!hex_stop_ff) begin
            if (digit.valid) begin
               hex_in      = {hex_ff[3:0], digit.value};
               hex_seen_in = 1'b1;
            end else begin
               hex_stop_in = 1'b1;
            end
         end
         result.field_length    = char_cnt_in;
         result.length_overflow = ovf_in;
      end

      result.end_marker_seen = mark_seen_in;

      if (final_byte) begin
         result.checksum_match    = hex_seen_in && (hex_in == latched_in);
         result.computed_checksum = latched_in;
         result.received_checksum = hex_in;
         // drop all sentence state
         xor_in       = 8'd0;
         latched_in   = 8'd0;
         mark_seen_in = 1'b0;
         field_cnt_in = 8'd0;
         char_cnt_in  = 6'd0;
         ovf_in       = 1'b0;
         hex_in       = 8'd0;
         hex_seen_in  = 1'b0;
         hex_stop_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff       <= 8'd0;
         latched_ff   <= 8'd0;
         mark_seen_ff <= 1'b0;
         field_cnt_ff <= 8'd0;
         char_cnt_ff  <= 6'd0;
         ovf_ff       <= 1'b0;
         hex_ff       <= 8'd0;
         hex_seen_ff  <= 1'b0;
         hex_stop_ff  <= 1'b0;
      end else if (advance) begin
         xor_ff       <= xor_in;
         latched_ff   <= latched_in;
         mark_seen_ff <= mark_seen_in;
         field_cnt_ff <= field_cnt_in;
         char_cnt_ff  <= char_cnt_in;
         ovf_ff       <= ovf_in;
         hex_ff       <= hex_in;
         hex_seen_ff  <= hex_seen_in;
         hex_stop_ff  <= hex_stop_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/nsfc_checker.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker port assertions
// Watches the result port of the sentence checksum block over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_field_checksum_defines.svh"

module nsfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_field_char,
   input wire logic       rsp_char_valid,
   input wire logic       rsp_field_end,
   input wire logic [5:0] rsp_field_length,
   input wire logic       rsp_sentence_done,
   input wire logic       rsp_checksum_match,
   input wire logic [7:0] rsp_computed_checksum,
   input wire logic [7:0] rsp_received_checksum
);

   // verdict fields stay zero except on the final byte
   `NSFC_ASSERT_NOW(a_verdict_quiet, clock, reset, rsp_valid && !rsp_sentence_done, !rsp_checksum_match && rsp_computed_checksum == 8'd0 && rsp_received_checksum == 8'd0, "verdict fields set before final byte")

   // a byte either joins a field or closes one
   `NSFC_ASSERT_NOW(a_char_or_end, clock, reset, rsp_valid, rsp_char_valid != rsp_field_end, "char_valid and field_end not exclusive")

   `NSFC_ASSERT_NOW(a_match_equal, clock, reset, rsp_valid && rsp_checksum_match, rsp_received_checksum == rsp_computed_checksum, "match flagged on unequal checksums")

   `NSFC_ASSERT_NOW(a_len_cap, clock, reset, rsp_valid, rsp_field_length <= nsfc_pkg::LEN_CAP, "field length above cap")

   `NSFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_field_char), "stalled response word changed")

endmodule

bind nmea_sentence_field_checksum nsfc_checker u_nsfc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_field_char        (rsp_field_char),
   .rsp_char_valid        (rsp_char_valid),
   .rsp_field_end         (rsp_field_end),
   .rsp_field_length      (rsp_field_length),
   .rsp_sentence_done     (rsp_sentence_done),
   .rsp_checksum_match    (rsp_checksum_match),
   .rsp_computed_checksum (rsp_computed_checksum),
   .rsp_received_checksum (rsp_received_checksum)
);

`default_nettype wire
